@@ hdl/frmt_pkg.sv @@
// Shared types and constants for the fixed region map table.
// No dependencies; imported by frmt_ovl, the top module and the testbench.
package frmt_pkg;

   localparam int TABLE_SLOTS_DEF = 16;
   localparam int PAGE_SHIFT_DEF  = 12;

   localparam logic       CMD_INSERT = 1'b0;
   localparam logic       CMD_READ   = 1'b1;

   localparam logic [32:0] WINDOW_LOW  = 33'h0_6000_0000;
   localparam logic [32:0] WINDOW_HIGH = 33'h0_8000_0000;

   localparam int FLAG_SHARED_BIT = 1;
   localparam int FLAG_FIXED_BIT  = 3;

   localparam logic [4:0] COUNT_MAX = 5'd31;

   typedef struct packed {
      logic [31:0] start;
      logic [30:0] length;
      logic [31:0] flags;
      logic [31:0] descriptor;
   } entry_type;

   typedef struct packed {
      logic [31:0] lo;
      logic [32:0] hi;
   } range_type;

endpackage

@@ hdl/frmt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/frmt_ovl.sv @@
// Range overlap compare shared by every slot of the scan.
// Depends on frmt_pkg (range_type, entry_type).
module frmt_ovl (
   input  frmt_pkg::range_type req_range,
   input  frmt_pkg::entry_type entry,
   output logic                overlap
);
   import frmt_pkg::*;

   logic [32:0] entry_lo;
   logic [32:0] entry_hi;

   assign entry_lo = {1'b0, entry.start};
   assign entry_hi = entry_lo + {2'b00, entry.length};
   assign overlap  = ({1'b0, req_range.lo} < entry_hi) && (req_range.hi > entry_lo);

endmodule

@@ hdl/fixed_region_map_table_top.sv @@
// Fixed region map table: insert of fixed mappings with overlap check, slot read.
// Insert: one overlap compare per slot in ST_SCAN (through the shared compare unit and the
// table RAM read port), then the store in ST_FINISH; a rejected request goes straight to
// ST_DONE; a read passes ST_RDREQ and ST_RDDATA. ST_DONE waits while an untaken beat holds
// rsp_valid; req_ready returns with rsp_valid, so one request is in flight at a time.
// Synchronous reset clears the used flags, the mapping count and all handshake state.
module fixed_region_map_table_top #(
   parameter int TABLE_SLOTS = frmt_pkg::TABLE_SLOTS_DEF,
   parameter int PAGE_SHIFT  = frmt_pkg::PAGE_SHIFT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [31:0]        req_addr,
   input  logic signed [31:0] req_length,
   input  logic [31:0]        req_flags,
   input  logic signed [31:0] req_descriptor,
   input  logic [3:0]         req_slot_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_status,
   output logic [31:0]        rsp_addr_out,
   output logic [30:0]        rsp_length_out,
   output logic               rsp_slot_used,
   output logic [4:0]         rsp_mapping_count
);
   import frmt_pkg::*;

   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_FINISH = 3'd2;
   localparam logic [2:0] ST_RDREQ  = 3'd3;
   localparam logic [2:0] ST_RDDATA = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [31:0]            addr_ff, addr_in;
   logic [30:0]            len_ff, len_in;
   logic [31:0]            flags_ff, flags_in;
   logic [31:0]            desc_ff, desc_in;
   logic [3:0]             slot_ff, slot_in;
   logic [32:0]            hi_ff, hi_in;
   logic [SLOT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                   cmp_pend_ff, cmp_pend_in;
   logic                   hit_ff, hit_in;
   logic                   free_found_ff, free_found_in;
   logic [SLOT_W-1:0]      free_idx_ff, free_idx_in;
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [4:0]             count_ff, count_in;
   logic                   res_status_ff, res_status_in;
   logic [31:0]            res_addr_ff, res_addr_in;
   logic [30:0]            res_len_ff, res_len_in;
   logic                   res_used_ff, res_used_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_addr_ff, rsp_addr_in;
   logic [30:0]            rsp_len_ff, rsp_len_in;
   logic                   rsp_used_ff, rsp_used_in;
   logic [4:0]             rsp_count_ff, rsp_count_in;

   logic [32:0]       req_hi;
   logic              pre_ok;
   logic [SLOT_W-1:0] slot_addr;
   logic              slot_in_range;
   logic              overlap;
   logic              hit_all;
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   entry_type         ram_wr_data;
   entry_type         ram_rd_data;
   range_type         cur_range;

   assign req_hi = {1'b0, req_addr} + {1'b0, req_length};

   assign pre_ok = !req_length[31] && (req_length != 32'sd0)
                   && (req_addr != 32'd0) && (req_addr[PAGE_SHIFT-1:0] == '0)
                   && req_flags[FLAG_SHARED_BIT] && req_flags[FLAG_FIXED_BIT]
                   && ({1'b0, req_addr} >= WINDOW_LOW) && (req_hi <= WINDOW_HIGH);

   assign slot_addr     = SLOT_W'(slot_ff);
   assign slot_in_range = 32'(slot_ff) < 32'(TABLE_SLOTS);

   assign cur_range.lo = addr_ff;
   assign cur_range.hi = hi_ff;

   assign ram_rd_addr = (state_ff == ST_RDREQ) ? slot_addr : scan_idx_ff;
   assign ram_wr_data = '{start: addr_ff, length: len_ff, flags: flags_ff,
                          descriptor: desc_ff};
   assign hit_all     = hit_ff | (cmp_pend_ff & overlap);
   assign ram_wr_en   = (state_ff == ST_FINISH) && !hit_all && free_found_ff;

   frmt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_SLOTS),
      .AW    (SLOT_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   frmt_ovl u_ovl (
      .req_range (cur_range),
      .entry     (ram_rd_data),
      .overlap   (overlap)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      flags_in      = flags_ff;
      desc_in       = desc_ff;
      slot_in       = slot_ff;
      hi_in         = hi_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_pend_in   = cmp_pend_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_len_in    = res_len_ff;
      res_used_in   = res_used_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_count_in  = rsp_count_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               addr_in  = req_addr;
               len_in   = req_length[30:0];
               flags_in = req_flags;
               desc_in  = req_descriptor;
               slot_in  = req_slot_index;
               hi_in    = req_hi;
               if (req_cmd == CMD_READ) begin
                  state_in = ST_RDREQ;
               end else if (pre_ok) begin
                  scan_idx_in   = '0;
                  cmp_pend_in   = 1'b0;
                  hit_in        = 1'b0;
                  free_found_in = 1'b0;
                  state_in      = ST_SCAN;
               end else begin
                  res_status_in = 1'b1;
                  res_addr_in   = '0;
                  res_len_in    = '0;
                  res_used_in   = 1'b0;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            cmp_pend_in = valid_ff[scan_idx_ff];
            hit_in      = hit_all;
            if (!valid_ff[scan_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_idx_ff;
            end
            if (scan_idx_ff == LAST_SLOT) begin
               state_in = ST_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            cmp_pend_in = 1'b0;
            res_len_in  = '0;
            res_used_in = 1'b0;
            if (ram_wr_en) begin
               valid_in[free_idx_ff] = 1'b1;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 5'd1;
               end
               res_status_in = 1'b0;
               res_addr_in   = addr_ff;
            end else begin
               res_status_in = 1'b1;
               res_addr_in   = '0;
            end
            state_in = ST_DONE;
         end
         ST_RDREQ: begin
            state_in = ST_RDDATA;
         end
         ST_RDDATA: begin
            res_status_in = !slot_in_range;
            res_used_in   = slot_in_range && valid_ff[slot_addr];
            res_addr_in   = res_used_in ? ram_rd_data.start : '0;
            res_len_in    = res_used_in ? ram_rd_data.length : '0;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_len_in    = res_len_ff;
               rsp_used_in   = res_used_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_pend_ff  <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_pend_ff  <= cmp_pend_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      flags_ff      <= flags_in;
      desc_ff       <= desc_in;
      slot_ff       <= slot_in;
      hi_ff         <= hi_in;
      scan_idx_ff   <= scan_idx_in;
      hit_ff        <= hit_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_len_ff    <= res_len_in;
      res_used_ff   <= res_used_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_addr_out      = rsp_addr_ff;
   assign rsp_length_out    = rsp_len_ff;
   assign rsp_slot_used     = rsp_used_ff;
   assign rsp_mapping_count = rsp_count_ff;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for fixed_region_map_table_top: directed and random insert/read beats,
// predicted in-line and compared per field. Depends on frmt_pkg and the block's RTL only.
module testbench;
   import frmt_pkg::*;

   localparam int RANDOM_ITEMS   = 1430;
   localparam int QUIET_TAIL     = 120;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 30;
   localparam logic [31:0] FLAGS_OK   = (32'd1 << FLAG_SHARED_BIT) | (32'd1 << FLAG_FIXED_BIT);
   localparam logic [31:0] PAGE_BYTES = 32'd1 << PAGE_SHIFT_DEF;

   typedef struct packed {
      logic        cmd;
      logic [31:0] addr;
      logic [31:0] length;
      logic [31:0] flags;
      logic [31:0] descriptor;
      logic [3:0]  slot;
      logic        drain;
   } map_request_type;

   typedef struct packed {
      logic        status;
      logic [31:0] addr;
      logic [30:0] length;
      logic        used;
      logic [4:0]  count;
   } map_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd = CMD_READ;
   logic [31:0]        req_addr = '0;
   logic signed [31:0] req_length = '0;
   logic [31:0]        req_flags = '0;
   logic signed [31:0] req_descriptor = '0;
   logic [3:0]         req_slot_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_status;
   logic [31:0]        rsp_addr_out;
   logic [30:0]        rsp_length_out;
   logic               rsp_slot_used;
   logic [4:0]         rsp_mapping_count;

   map_request_type pending_requests[$];
   map_result_type  expected_results[$];
   map_request_type cur_request;
   map_result_type  want;

   bit        map_used[TABLE_SLOTS_DEF];
   bit [31:0] map_start[TABLE_SLOTS_DEF];
   bit [30:0] map_length[TABLE_SLOTS_DEF];
   bit [4:0]  map_count;

   int  fail_count = 0;
   int  sent_total = 0;
   int  checked_total = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   bit  quiet_tail = 1'b0;
   bit  hold_next = 1'b0;

   fixed_region_map_table_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit calm_stretch(input int n);
      return (n / 100) % 3 == 2;
   endfunction

   function automatic map_result_type predict_map_result(input map_request_type r);
      map_result_type res;
      logic [33:0] lo, hi, elo, ehi;
      logic        ok;
      int          free_slot;
      res = '0;
      res.status = 1'b1;
      if (r.cmd == CMD_INSERT) begin
         lo = {2'b00, r.addr};
         hi = lo + {2'b00, r.length};
         ok = (r.length != 0) && !r.length[31];
         if (r.addr == 0 || r.addr[PAGE_SHIFT_DEF-1:0] != 0) ok = 1'b0;
         if (!r.flags[FLAG_SHARED_BIT] || !r.flags[FLAG_FIXED_BIT]) ok = 1'b0;
         if (lo < {1'b0, WINDOW_LOW} || hi > {1'b0, WINDOW_HIGH}) ok = 1'b0;
         free_slot = -1;
         for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
            elo = {2'b00, map_start[i]};
            ehi = elo + {3'b000, map_length[i]};
            if (map_used[i] && lo < ehi && hi > elo) ok = 1'b0;
            if (!map_used[i] && free_slot < 0) free_slot = i;
         end
         if (free_slot < 0) ok = 1'b0;
         if (ok) begin
            map_used[free_slot]   = 1'b1;
            map_start[free_slot]  = r.addr;
            map_length[free_slot] = r.length[30:0];
            if (map_count < COUNT_MAX) map_count++;
            res.status = 1'b0;
            res.addr   = r.addr;
         end
      end else if (int'(r.slot) < TABLE_SLOTS_DEF) begin
         res.status = 1'b0;
         if (map_used[r.slot]) begin
            res.used   = 1'b1;
            res.addr   = map_start[r.slot];
            res.length = map_length[r.slot];
         end
      end
      res.count = map_count;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      $display("mismatch on %s at beat %0d: got %h, want %h", field, checked_total, got, exp_val);
      fail_count++;
   endtask

   task automatic push_insert(input logic [31:0] addr, input logic [31:0] length,
                              input logic [31:0] flags, input logic [31:0] descriptor);
      map_request_type r;
      r.cmd        = CMD_INSERT;
      r.addr       = addr;
      r.length     = length;
      r.flags      = flags;
      r.descriptor = descriptor;
      r.slot       = 4'($urandom_range(0, 15));
      r.drain      = hold_next;
      hold_next    = 1'b0;
      pending_requests.push_back(r);
   endtask

   task automatic push_read(input logic [3:0] slot);
      map_request_type r;
      r.cmd        = CMD_READ;
      r.addr       = $urandom();
      r.length     = $urandom();
      r.flags      = $urandom();
      r.descriptor = $urandom();
      r.slot       = slot;
      r.drain      = hold_next;
      hold_next    = 1'b0;
      pending_requests.push_back(r);
   endtask

   task automatic push_random_item();
      map_request_type r;
      logic [159:0]    raw;
      logic [31:0]     addr, length;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7: push_read(4'($urandom_range(0, 15)));
         17, 18, 19: begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            r = raw[$bits(map_request_type)-1:0];
            r.drain = 1'b0;
            pending_requests.push_back(r);
         end
         default: begin
            case ($urandom_range(0, 3))
               0, 1: addr = WINDOW_LOW[31:0] + ($urandom_range(0, 63) << PAGE_SHIFT_DEF);
               2: addr = WINDOW_HIGH[31:0] - ($urandom_range(1, 64) << PAGE_SHIFT_DEF);
               default: addr = WINDOW_LOW[31:0] + ($urandom_range(0, 32'h1FFFF) << PAGE_SHIFT_DEF);
            endcase
            if ($urandom_range(0, 7) == 0) length = $urandom_range(1, 32'h7FFF_FFFF);
            else length = $urandom_range(1, 4 * PAGE_BYTES);
            push_insert(addr, length, $urandom() | FLAGS_OK, $urandom());
         end
      endcase
   endtask

   // drive the request channel from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_map_result(cur_request));
            sent_total++;
         end
         quiet_tail = pending_requests.size() < QUIET_TAIL;
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain && expected_results.size() != 0)) begin
               cur_request = pending_requests.pop_front();
               req_valid      <= 1'b1;
               req_cmd        <= cur_request.cmd;
               req_addr       <= cur_request.addr;
               req_length     <= cur_request.length;
               req_flags      <= cur_request.flags;
               req_descriptor <= cur_request.descriptor;
               req_slot_index <= cur_request.slot;
               if (!quiet_tail && !calm_stretch(sent_total) && $urandom_range(0, 3) == 0)
                  gap_left = $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // check each result beat and stall the result channel in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat", rsp_addr_out, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_addr_out !== want.addr)
                  report_mismatch("addr_out", rsp_addr_out, want.addr);
               if (rsp_length_out !== want.length)
                  report_mismatch("length_out", 32'(rsp_length_out), 32'(want.length));
               if (rsp_slot_used !== want.used)
                  report_mismatch("slot_used", 32'(rsp_slot_used), 32'(want.used));
               if (rsp_mapping_count !== want.count)
                  report_mismatch("mapping_count", 32'(rsp_mapping_count), 32'(want.count));
            end
            checked_total++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && !calm_stretch(checked_total) && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      push_read(4'd0);
      push_read(4'd15);
      push_insert(32'h6000_0000, 32'h0000_0000, FLAGS_OK, 32'h0);
      push_insert(32'h6000_0000, 32'h8000_0000, FLAGS_OK, 32'h7FFF_FFFF);
      push_insert(32'h6000_0000, 32'hFFFF_FFFF, FLAGS_OK, 32'h8000_0000);
      push_insert(32'h0000_0000, PAGE_BYTES, FLAGS_OK, 32'h1);
      push_insert(32'h6000_0800, PAGE_BYTES, FLAGS_OK, 32'h2);
      push_insert(32'h6000_0000, PAGE_BYTES, 32'd1 << FLAG_FIXED_BIT, 32'h3);
      push_insert(32'h6000_0000, PAGE_BYTES, 32'd1 << FLAG_SHARED_BIT, 32'h4);
      push_insert(32'h5FFF_F000, PAGE_BYTES, FLAGS_OK, 32'h5);
      push_insert(32'h7FFF_F000, 2 * PAGE_BYTES, FLAGS_OK, 32'h6);
      push_insert(32'hFFFF_F000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_insert(32'h6000_0000, PAGE_BYTES, 32'hFFFF_FFFF, 32'h8000_0000);
      push_insert(32'h7FFF_F000, PAGE_BYTES, FLAGS_OK, 32'h7FFF_FFFF);
      push_insert(32'h6000_0000, 32'h1, FLAGS_OK, 32'h7);
      push_insert(32'h7FFF_E000, PAGE_BYTES + 1, FLAGS_OK, 32'h8);
      push_insert(32'h6000_1000, 32'h1, FLAGS_OK, 32'h9);
      push_insert(32'h6000_3000, 32'h7FFF_FFFF, FLAGS_OK, 32'hA);
      hold_next = 1'b1;
      push_read(4'd0);
      push_read(4'd1);
      push_read(4'd2);
      push_read(4'd3);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) hold_next = 1'b1;
         push_random_item();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/frmt_pkg.sv
hdl/frmt_ram.sv
hdl/frmt_ovl.sv
hdl/fixed_region_map_table_top.sv
tb/sv/testbench.sv
